// ===== rtl/core/wttvl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wttvl_pkg
// Shared types and constants of the wheel torque-to-voltage loop.
// ----------------------------------------------------------------------------
package wttvl_pkg;

  localparam int WHEELS    = 4;
  localparam int DIV_STEPS = 64;

  localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
  localparam logic [30:0] LIM_POS    = 31'h7FFF_FFFF;
  localparam logic [62:0] Q_CAP      = 63'h4000_0000_0000_0000;

  localparam logic [1:0] REG_VMIN  = 2'd0;
  localparam logic [1:0] REG_VMAX  = 2'd1;
  localparam logic [1:0] REG_GAIN  = 2'd2;
  localparam logic [1:0] REG_COUNT = 2'd3;

  typedef struct packed {
    logic               opcode;
    logic [1:0]         wheel_index;
    logic [63:0]        call_time;
    logic               speed_feedback_on;
    logic               wheel_available;
    logic signed [31:0] torque_command;
    logic signed [31:0] wheel_speed;
    logic [30:0]        wheel_inertia;
    logic [30:0]        torque_limit;
    logic               last_wheel;
  } wttvl_in_t;

  typedef struct packed {
    logic [1:0]         wheel_number;
    logic signed [31:0] drive_voltage;
    logic               call_done;
  } wttvl_out_t;

  typedef struct packed {
    logic [30:0] voltage_min;
    logic [30:0] voltage_max;
    logic [30:0] gain_k;
    logic [2:0]  wheel_count;
  } wttvl_cfg_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_LOAD,
    OP_DECIDE,
    OP_F_MUL1,
    OP_F_MUL2,
    OP_F_MUL3,
    OP_F_ACC,
    OP_F_DIV,
    OP_F_ERR,
    OP_F_GMUL,
    OP_F_CORR,
    OP_V_MUL,
    OP_V_CHECK,
    OP_V_DIV,
    OP_V_OUT,
    OP_FINISH
  } wttvl_op_e;

  typedef struct packed {
    wttvl_op_e op;
  } wttvl_cmd_t;

  typedef struct packed {
    logic is_load;
    logic fb_go;
    logic volt_go;
    logic prod_zero;
    logic div_busy;
    logic out_busy;
  } wttvl_status_t;

endpackage

// ===== rtl/core/wttvl_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wttvl_div
// Restoring divider, one quotient bit per cycle, 64-bit quotient with an overflow flag.
// ----------------------------------------------------------------------------
module wttvl_div import wttvl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [92:0] num_i,
  input  logic [63:0] den_i,
  output logic        busy_o,
  output logic [63:0] quot_o,
  output logic        sat_o
);

  logic [63:0] rem_q, rem_d, quo_q, quo_d, den_q;
  logic        sat_q, busy_q, busy_d, ge;
  logic [5:0]  cnt_q, cnt_d;
  logic [64:0] sh;
  logic [64:0] diff;

  assign sh   = {rem_q, quo_q[63]};
  assign ge   = sh >= {1'b0, den_q};
  assign diff = sh - {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = {35'd0, num_i[92:64]};
      quo_d  = num_i[63:0];
      cnt_d  = 6'(DIV_STEPS - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[63:0] : sh[63:0];
      quo_d = {quo_q[62:0], ge};
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= den_i;
      sat_q <= {35'd0, num_i[92:64]} >= den_i;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;
  assign sat_o  = sat_q;

endmodule

// ===== rtl/core/wttvl_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wttvl_dp
// Datapath: wheel tables, loop state, shared multiplier and divider, output.
// ----------------------------------------------------------------------------
module wttvl_dp import wttvl_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  wttvl_cmd_t    cmd_i,
  input  wttvl_cfg_t    cfg_i,
  input  wttvl_in_t     in_req_i,
  input  logic          out_ready_i,
  output wttvl_status_t status_o,
  output logic          out_valid_o,
  output wttvl_out_t    out_req_o
);

  wttvl_in_t          in_q;
  logic [30:0]        inertia_q [WHEELS];
  logic [30:0]        limit_q [WHEELS];
  logic signed [31:0] prev_speed_q [WHEELS];
  logic [63:0]        pct_q;
  logic               fresh_q;
  logic [63:0]        dt_q, prod_q;
  logic [65:0]        mul_q;
  logic [92:0]        num_q;
  logic signed [31:0] tq_q, volt_q;
  logic signed [32:0] err_q;
  logic               fsgn_q, vneg_q, fbgate_q, used_q;
  logic               out_valid_q;
  wttvl_out_t         out_q;

  logic [32:0]        mul_a, mul_b;
  logic [65:0]        mul_p;
  logic               used, fbgate;
  logic [63:0]        dt;
  logic signed [32:0] dspeed;
  logic [32:0]        dmag, emag;
  logic [47:0]        jam48, csh;
  logic [30:0]        jmag, cmag, smag, vmag;
  logic signed [32:0] ja, corr;
  logic signed [33:0] tnew;
  logic signed [31:0] tclamp, span;
  logic [31:0]        tmag;
  logic [62:0]        qc;
  logic [63:0]        vsum;
  logic               div_start, div_busy, div_sat;
  logic [63:0]        div_q, div_den;

  assign used   = cfg_i.wheel_count > {1'b0, in_q.wheel_index};
  assign fbgate = in_q.speed_feedback_on && (pct_q != 64'd0);
  assign dt     = in_q.call_time - pct_q;

  assign dspeed = {in_q.wheel_speed[31], in_q.wheel_speed}
                - {prev_speed_q[in_q.wheel_index][31], prev_speed_q[in_q.wheel_index]};
  assign dmag   = dspeed[32] ? 33'(-dspeed) : 33'(dspeed);
  assign emag   = err_q[32] ? 33'(-err_q) : 33'(err_q);
  assign span   = $signed({1'b0, cfg_i.voltage_max}) - $signed({1'b0, cfg_i.voltage_min});
  assign smag   = span[31] ? 31'(-span) : span[30:0];
  assign tmag   = tq_q[31] ? 32'(-tq_q) : 32'(tq_q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_F_MUL1: begin
        mul_a = {2'b0, inertia_q[in_q.wheel_index]};
        mul_b = dmag;
      end
      OP_F_MUL2: begin
        mul_a = {1'b0, mul_q[31:0]};
        mul_b = {3'b0, NS_PER_SEC};
      end
      OP_F_MUL3: begin
        mul_a = {1'b0, prod_q[63:32]};
        mul_b = {3'b0, NS_PER_SEC};
      end
      OP_F_GMUL: begin
        mul_a = {2'b0, cfg_i.gain_k};
        mul_b = emag;
      end
      OP_V_MUL: begin
        mul_a = {2'b0, smag};
        mul_b = {1'b0, tmag};
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // acceleration term and correction
  assign jam48 = div_sat ? 48'hFFFF_FFFF_FFFF : div_q[63:16];
  assign jmag  = (jam48[47:31] != '0) ? LIM_POS : jam48[30:0];
  assign ja    = fsgn_q ? -$signed({2'b0, jmag}) : $signed({2'b0, jmag});
  assign csh   = mul_q[63:16];
  assign cmag  = (csh[47:31] != '0) ? LIM_POS : csh[30:0];
  assign corr  = err_q[32] ? -$signed({2'b0, cmag}) : $signed({2'b0, cmag});
  assign tnew  = {{2{tq_q[31]}}, tq_q} - {corr[32], corr};

  always_comb begin
    if (tnew > 34'sh0_7FFF_FFFF) begin
      tclamp = 32'sh7FFF_FFFF;
    end else if (tnew < -34'sh0_8000_0000) begin
      tclamp = 32'sh8000_0000;
    end else begin
      tclamp = tnew[31:0];
    end
  end

  // voltage magnitude
  assign qc   = (div_sat || div_q > {1'b0, Q_CAP}) ? Q_CAP : div_q[62:0];
  assign vsum = {1'b0, qc} + {33'd0, cfg_i.voltage_min};
  assign vmag = (vsum > {33'd0, cfg_i.voltage_max}) ? cfg_i.voltage_max : vsum[30:0];

  assign div_start = (cmd_i.op == OP_F_DIV) || (cmd_i.op == OP_V_DIV);
  assign div_den   = (cmd_i.op == OP_V_DIV) ? {33'd0, limit_q[in_q.wheel_index]} : dt_q;

  wttvl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (num_q),
    .den_i  (div_den),
    .busy_o (div_busy),
    .quot_o (div_q),
    .sat_o  (div_sat)
  );

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_CAPTURE: begin
        in_q <= in_req_i;
      end
      OP_LOAD: begin
        inertia_q[in_q.wheel_index] <= in_q.wheel_inertia;
        limit_q[in_q.wheel_index]   <= in_q.torque_limit;
      end
      OP_DECIDE: begin
        dt_q     <= dt;
        tq_q     <= in_q.torque_command;
        volt_q   <= '0;
        used_q   <= used;
        fbgate_q <= fbgate;
      end
      OP_F_MUL1: begin
        mul_q  <= mul_p;
        fsgn_q <= dspeed[32];
      end
      OP_F_MUL2: begin
        prod_q <= mul_q[63:0];
        mul_q  <= mul_p;
      end
      OP_F_MUL3: begin
        num_q <= 93'(mul_q);
        mul_q <= mul_p;
      end
      OP_F_ACC: begin
        num_q <= num_q + (93'(mul_q) << 32);
      end
      OP_F_ERR: begin
        err_q <= ja - {tq_q[31], tq_q};
      end
      OP_F_GMUL: begin
        mul_q <= mul_p;
      end
      OP_F_CORR: begin
        tq_q <= tclamp;
      end
      OP_V_MUL: begin
        mul_q  <= mul_p;
        vneg_q <= span[31] != tq_q[31];
      end
      OP_V_CHECK: begin
        num_q <= 93'(mul_q);
      end
      OP_V_OUT: begin
        volt_q <= vneg_q ? -$signed({1'b0, vmag}) : $signed({1'b0, vmag});
      end
      OP_FINISH: begin
        out_q.wheel_number  <= in_q.wheel_index;
        out_q.drive_voltage <= volt_q;
        out_q.call_done     <= in_q.last_wheel;
      end
      default: begin
      end
    endcase
  end

  // loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WHEELS; i++) begin
        prev_speed_q[i] <= '0;
      end
      pct_q       <= '0;
      fresh_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.op == OP_LOAD) begin
        for (int i = 0; i < WHEELS; i++) begin
          prev_speed_q[i] <= '0;
        end
        pct_q   <= '0;
        fresh_q <= 1'b1;
      end else if (cmd_i.op == OP_FINISH) begin
        out_valid_q <= 1'b1;
        if (used_q && fbgate_q) begin
          prev_speed_q[in_q.wheel_index] <= in_q.wheel_speed;
        end
        if (in_q.last_wheel && in_q.speed_feedback_on) begin
          if (pct_q != 64'd0) begin
            fresh_q <= 1'b0;
          end
          pct_q <= in_q.call_time;
        end
      end
    end
  end

  always_comb begin
    status_o.is_load   = !in_q.opcode;
    status_o.fb_go     = used && fbgate && in_q.wheel_available && !fresh_q && (dt != 64'd0);
    status_o.volt_go   = used && in_q.wheel_available;
    status_o.prod_zero = mul_q == '0;
    status_o.div_busy  = div_busy;
    status_o.out_busy  = out_valid_q && !out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

// ===== rtl/core/wttvl_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wttvl_ctrl
// Sequencer: steps one request through load, feedback and voltage phases.
// ----------------------------------------------------------------------------
module wttvl_ctrl import wttvl_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  wttvl_status_t status_i,
  output wttvl_cmd_t    cmd_o
);

  typedef enum logic [17:0] {
    S_IDLE   = 18'h00001,
    S_DECIDE = 18'h00002,
    S_LOAD   = 18'h00004,
    S_FM1    = 18'h00008,
    S_FM2    = 18'h00010,
    S_FM3    = 18'h00020,
    S_FACC   = 18'h00040,
    S_FDS    = 18'h00080,
    S_FDW    = 18'h00100,
    S_FERR   = 18'h00200,
    S_FGM    = 18'h00400,
    S_FCOR   = 18'h00800,
    S_VMUL   = 18'h01000,
    S_VCHK   = 18'h02000,
    S_VDS    = 18'h04000,
    S_VDW    = 18'h08000,
    S_VOUT   = 18'h10000,
    S_FIN    = 18'h20000
  } wttvl_state_e;

  wttvl_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_CAPTURE;
          state_d  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd_o.op = OP_DECIDE;
        if (status_i.is_load) begin
          state_d = S_LOAD;
        end else if (status_i.fb_go) begin
          state_d = S_FM1;
        end else if (status_i.volt_go) begin
          state_d = S_VMUL;
        end else begin
          state_d = S_FIN;
        end
      end
      S_LOAD: begin
        cmd_o.op = OP_LOAD;
        state_d  = S_IDLE;
      end
      S_FM1: begin
        cmd_o.op = OP_F_MUL1;
        state_d  = S_FM2;
      end
      S_FM2: begin
        cmd_o.op = OP_F_MUL2;
        state_d  = S_FM3;
      end
      S_FM3: begin
        cmd_o.op = OP_F_MUL3;
        state_d  = S_FACC;
      end
      S_FACC: begin
        cmd_o.op = OP_F_ACC;
        state_d  = S_FDS;
      end
      S_FDS: begin
        cmd_o.op = OP_F_DIV;
        state_d  = S_FDW;
      end
      S_FDW: begin
        if (!status_i.div_busy) begin
          state_d = S_FERR;
        end
      end
      S_FERR: begin
        cmd_o.op = OP_F_ERR;
        state_d  = S_FGM;
      end
      S_FGM: begin
        cmd_o.op = OP_F_GMUL;
        state_d  = S_FCOR;
      end
      S_FCOR: begin
        cmd_o.op = OP_F_CORR;
        state_d  = S_VMUL;
      end
      S_VMUL: begin
        cmd_o.op = OP_V_MUL;
        state_d  = S_VCHK;
      end
      S_VCHK: begin
        cmd_o.op = OP_V_CHECK;
        state_d  = status_i.prod_zero ? S_FIN : S_VDS;
      end
      S_VDS: begin
        cmd_o.op = OP_V_DIV;
        state_d  = S_VDW;
      end
      S_VDW: begin
        if (!status_i.div_busy) begin
          state_d = S_VOUT;
        end
      end
      S_VOUT: begin
        cmd_o.op = OP_V_OUT;
        state_d  = S_FIN;
      end
      S_FIN: begin
        if (!status_i.out_busy) begin
          cmd_o.op = OP_FINISH;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/wheel_torque_to_voltage_loop_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wheel_torque_to_voltage_loop_top
// Per-wheel torque command to drive voltage, with optional rate feedback.
// ----------------------------------------------------------------------------
// One request is handled at a time. A load request passes through the decide
// and load states, and a sample request for a wheel that is unavailable or not
// in use goes straight from the decide state to the finish state. One with a
// zero torque or zero voltage span ends after the voltage multiply and check.
// Any other sample request without feedback spends most of its time in one
// 64-step pass of the shared bit-serial divider; with feedback it runs twice.
// The result sits in an output register, so the next request is taken
// while it waits; a request only stalls when its own result is ready while the
// previous one is still held by the receiver.
module wheel_torque_to_voltage_loop_top import wttvl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  wttvl_in_t   in_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output wttvl_out_t  out_req_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  wttvl_cfg_t    cfg_q;
  wttvl_cmd_t    cmd;
  wttvl_status_t status;
  logic          cfg_we;

  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_VMIN:  cfg_q.voltage_min <= pwdata[30:0];
        REG_VMAX:  cfg_q.voltage_max <= pwdata[30:0];
        REG_GAIN:  cfg_q.gain_k      <= pwdata[30:0];
        REG_COUNT: cfg_q.wheel_count <= pwdata[2:0];
        default:   cfg_q.wheel_count <= cfg_q.wheel_count;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_VMIN:  prdata = {1'b0, cfg_q.voltage_min};
      REG_VMAX:  prdata = {1'b0, cfg_q.voltage_max};
      REG_GAIN:  prdata = {1'b0, cfg_q.gain_k};
      REG_COUNT: prdata = {29'd0, cfg_q.wheel_count};
      default:   prdata = '0;
    endcase
  end

  wttvl_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  wttvl_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_i      (cfg_q),
    .in_req_i   (in_req_i),
    .out_ready_i(out_ready_i),
    .status_o   (status),
    .out_valid_o(out_valid_o),
    .out_req_o  (out_req_o)
  );

endmodule

// ===== rtl/core/wttvl_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wttvl_chk
// Port-level checks of the wheel torque-to-voltage loop.
// ----------------------------------------------------------------------------
module wttvl_chk import wttvl_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input wttvl_out_t out_req_o,
  input logic       pready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_req_o))
    else $error("result dropped or changed while stalled");

  // one request in flight: busy right after accepting
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while another is in work");

  // a new result only appears after the block has been busy
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without preceding work");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind wheel_torque_to_voltage_loop_top wttvl_chk u_wttvl_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_req_o  (out_req_o),
  .pready     (pready)
);

// ===== test/wheel_voltage_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wheel_voltage_checker
// Watches the request, result and register ports of the wheel torque-to-voltage
// loop, keeps its own model of the loop state and the registers, works out the
// drive voltage for every accepted sample request and compares each accepted
// result against the oldest outstanding voltage.
// ----------------------------------------------------------------------------
module wheel_voltage_checker import wttvl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  wttvl_in_t   in_req_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  wttvl_out_t  out_req_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [3:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam longint unsigned LIM = 64'h7FFF_FFFF;

  longint unsigned vmin, vmax, gain, count;
  longint          spd_hist [WHEELS];
  longint unsigned inertia_tab [WHEELS];
  longint unsigned limit_tab [WHEELS];
  longint unsigned last_time;
  bit              fresh;
  wttvl_out_t      expected_volts [$];

  function automatic longint unsigned mag64(longint x);
    return x < 0 ? longint'(-x) : x;
  endfunction

  function automatic longint sat_lim(longint unsigned m, bit neg);
    if (m > LIM) m = LIM;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint corrected_torque(int w, longint torque, longint speed,
                                              longint unsigned dt);
    longint          dsp, ja, err, corr, t;
    longint unsigned prod, q64, gs;
    logic [127:0]    num, quo, gp;
    dsp  = speed - spd_hist[w];
    prod = inertia_tab[w] * mag64(dsp);
    num  = {64'b0, prod} * 128'd1000000000;
    quo  = num / {64'b0, dt};
    q64  = (quo[127:64] != 0) ? '1 : quo[63:0];
    ja   = sat_lim(q64 >> 16, dsp < 0);
    err  = ja - torque;
    gp   = {64'b0, gain} * {64'b0, mag64(err)};
    gs   = (gp[127:80] != 0) ? '1 : gp[79:16];
    corr = sat_lim(gs, err < 0);
    t    = torque - corr;
    if (t > longint'(LIM)) t = LIM;
    if (t < -longint'(LIM) - 1) t = -longint'(LIM) - 1;
    return t;
  endfunction

  function automatic longint torque_voltage(int w, longint torque);
    longint          span, v;
    longint unsigned q;
    logic [127:0]    prod, quo;
    span = longint'(vmax) - longint'(vmin);
    prod = {64'b0, mag64(span)} * {64'b0, mag64(torque)};
    if (prod == 0) return 0;
    if (limit_tab[w] == 0) q = '1;
    else begin
      quo = prod / {64'b0, limit_tab[w]};
      q = (quo[127:64] != 0) ? '1 : quo[63:0];
    end
    if (q > 64'h4000_0000_0000_0000) q = 64'h4000_0000_0000_0000;
    v = longint'(q + vmin);
    if ((span < 0) != (torque < 0)) v = -v;
    if (v > longint'(vmax)) v = vmax;
    if (v < -longint'(vmax)) v = -longint'(vmax);
    return v;
  endfunction

  task automatic predict_request(wttvl_in_t r);
    int              w, used;
    longint          torque, speed, volt;
    longint unsigned dt;
    wttvl_out_t      res;
    w      = r.wheel_index;
    torque = longint'(r.torque_command);
    speed  = longint'(r.wheel_speed);
    used   = count < WHEELS ? int'(count) : WHEELS;
    volt   = 0;
    if (!r.opcode) begin
      inertia_tab[w] = r.wheel_inertia;
      limit_tab[w]   = r.torque_limit;
      foreach (spd_hist[i]) spd_hist[i] = 0;
      fresh     = 1;
      last_time = 0;
      return;
    end
    if (w < used) begin
      if (r.speed_feedback_on && last_time != 0) begin
        dt = r.call_time - last_time;
        if (r.wheel_available && !fresh && dt != 0)
          torque = corrected_torque(w, torque, speed, dt);
        spd_hist[w] = speed;
      end
      if (r.wheel_available) volt = torque_voltage(w, torque);
    end
    if (r.last_wheel && r.speed_feedback_on) begin
      if (last_time != 0) fresh = 0;
      last_time = r.call_time;
    end
    res.wheel_number  = r.wheel_index;
    res.drive_voltage = volt[31:0];
    res.call_done     = r.last_wheel;
    expected_volts.push_back(res);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    wttvl_out_t want;
    if (!rst_ni) begin
      vmin = 0; vmax = 0; gain = 0; count = 0;
      foreach (spd_hist[i]) begin
        spd_hist[i] = 0; inertia_tab[i] = 0; limit_tab[i] = 0;
      end
      last_time = 0;
      fresh = 1;
      expected_volts.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_volts.size() == 0) begin
          $error("result with no voltage outstanding: %p", out_req_i);
          fail_count_o++;
        end else begin
          want = expected_volts.pop_front();
          if (out_req_i !== want) fail_count_o++;
          if (out_req_i.wheel_number !== want.wheel_number)
            $error("wheel_number expected %0d got %0d", want.wheel_number,
                   out_req_i.wheel_number);
          if (out_req_i.drive_voltage !== want.drive_voltage)
            $error("drive_voltage expected %0d got %0d", want.drive_voltage,
                   out_req_i.drive_voltage);
          if (out_req_i.call_done !== want.call_done)
            $error("call_done expected %0d got %0d", want.call_done,
                   out_req_i.call_done);
        end
      end
      if (in_valid_i && in_ready_i) predict_request(in_req_i);
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[3:2])
          REG_VMIN:  vmin  = pwdata_i[30:0];
          REG_VMAX:  vmax  = pwdata_i[30:0];
          REG_GAIN:  gain  = pwdata_i[30:0];
          REG_COUNT: count = pwdata_i[2:0];
          default: ;
        endcase
      end
    end
    pending_o = expected_volts.size();
  end

endmodule

// ===== test/wheel_torque_to_voltage_loop_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wheel_torque_to_voltage_loop_top_tb
// Drives load and sample requests and register writes into the wheel
// torque-to-voltage loop: a directed opening over extreme torques, the start
// of rate feedback, zero time steps, unavailable wheels and a zero torque
// limit, then random control calls under several register settings, with
// random idling on both sides and one long result stall.
// ----------------------------------------------------------------------------
module wheel_torque_to_voltage_loop_top_tb;
  import wttvl_pkg::*;

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  wttvl_in_t   in_req_i;
  wttvl_out_t  out_req_o;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          fail_count, pending;
  bit          quiet, long_stall_go;
  longint unsigned call_clock;
  int          sent;

  wheel_torque_to_voltage_loop_top i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_req_i,
    .out_valid_o, .out_ready_i, .out_req_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  wheel_voltage_checker i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_req_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_req_i(out_req_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // result side idling, with one long hold-off
  initial begin
    int  hold;
    bit  stall_done;
    hold = 0;
    stall_done = 0;
    out_ready_i = 0;
    forever begin
      @(negedge clk_i);
      if (long_stall_go && !stall_done) begin
        hold = 2000;
        stall_done = 1;
      end
      if (hold > 0) begin
        hold--;
        out_ready_i = 0;
      end else out_ready_i = quiet ? 1'b1 : ($urandom_range(99) >= 32);
    end
  end

  task automatic send_request(wttvl_in_t r);
    if (!quiet && $urandom_range(99) < 32) begin
      in_valid_i = 0;
      do @(negedge clk_i); while ($urandom_range(99) < 32);
    end
    in_req_i = r;
    in_valid_i = 1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    sent++;
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel = 1; pwrite = 1; penable = 0; paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk_i);
    penable = 1;
    @(negedge clk_i);
    psel = 0; penable = 0;
  endtask

  task automatic configure(logic [30:0] lo, logic [30:0] hi, logic [30:0] g,
                           logic [2:0] n);
    in_valid_i = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    reg_write(REG_VMIN, {1'b0, lo});
    reg_write(REG_VMAX, {1'b0, hi});
    reg_write(REG_GAIN, {1'b0, g});
    reg_write(REG_COUNT, {29'd0, n});
  endtask

  function automatic wttvl_in_t load_req(logic [1:0] w, logic [30:0] inertia,
                                         logic [30:0] lim);
    wttvl_in_t r;
    r = '0;
    r.wheel_index = w;
    r.wheel_inertia = inertia;
    r.torque_limit = lim;
    r.call_time = {$urandom, $urandom};
    return r;
  endfunction

  function automatic wttvl_in_t sample_req(logic [1:0] w, longint unsigned t, bit fb,
                                           bit avail, int torque, int speed, bit last);
    wttvl_in_t r;
    r.opcode = 1;
    r.wheel_index = w;
    r.call_time = t;
    r.speed_feedback_on = fb;
    r.wheel_available = avail;
    r.torque_command = torque;
    r.wheel_speed = speed;
    r.wheel_inertia = $urandom;
    r.torque_limit = $urandom;
    r.last_wheel = last;
    return r;
  endfunction

  task automatic random_call(int n);
    wttvl_in_t r;
    int        pick;
    logic [1:0] w;
    pick = $urandom_range(99);
    if (pick < 5) call_clock = call_clock;
    else if (pick < 10) call_clock = {$urandom, $urandom};
    else if (pick < 40) call_clock += $urandom_range(1 << 20, 1);
    else call_clock += 1_000_000 + $urandom_range(100000);
    for (int k = 0; k < n; k++) begin
      w = ($urandom_range(9) == 0) ? 2'($urandom) : 2'(k);
      r = sample_req(w, call_clock, $urandom_range(9) != 0, $urandom_range(99) < 85,
                     int'($urandom) >>> $urandom_range(31, 0),
                     ($urandom_range(3) == 0) ? int'($urandom)
                       : int'($urandom) >>> $urandom_range(31, 10),
                     k == n - 1);
      send_request(r);
    end
  endtask

  task automatic noise_request();
    wttvl_in_t    r;
    logic [223:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    r = raw[$bits(wttvl_in_t)-1:0];
    if (r.opcode && $urandom_range(1)) r.opcode = 0;
    if (!r.opcode && $urandom_range(7) == 0) r.torque_limit = 0;
    send_request(r);
  endtask

  initial begin
    longint unsigned t0;
    int target;
    rst_ni = 0;
    in_valid_i = 0;
    in_req_i = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    quiet = 0;
    long_stall_go = 0;
    sent = 0;
    call_clock = 1000;
    repeat (6) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    configure(31'h0001_0000, 31'h000C_0000, 31'h0000_8000, 3'd4);
    send_request(load_req(2'd0, 31'h0100_0000, 31'h7FFF_FFFF));
    send_request(load_req(2'd1, 31'h7FFF_FFFF, 31'd1));
    send_request(load_req(2'd2, 31'd0, 31'h0200_0000));
    send_request(load_req(2'd3, 31'h0080_0000, 31'h0100_0000));
    // first calls only record time, the third starts the feedback
    t0 = 1000;
    for (int c = 0; c < 4; c++) begin
      if (c != 3) t0 += 1_000_000;
      send_request(sample_req(2'd0, t0, 1, 1, 32'h7FFF_FFFF, c * 32'h0001_0000, 0));
      send_request(sample_req(2'd1, t0, 1, 1, 32'h8000_0000, -c * 32'h0010_0000, 0));
      send_request(sample_req(2'd2, t0, 1, 1, 0, 32'h7FFF_FFFF, 0));
      send_request(sample_req(2'd3, t0, 1, c != 1, -1, 32'h8000_0000, 1));
    end
    send_request(sample_req(2'd0, t0 + 5, 0, 1, 32'h0100_0000, 0, 1));
    send_request(load_req(2'd2, 31'h0100_0000, 31'd0));
    send_request(sample_req(2'd2, t0, 1, 1, 32'h0000_0100, 0, 1));

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: configure(31'h0000_8000, 31'h0018_0000, 31'h0001_0000, 3'd4);
        1: configure(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 3'd7);
        2: configure(31'h0010_0000, 31'h0008_0000, 31'h0000_4000, 3'd3);
        3: configure(31'd0, 31'h7FFF_FFFF, 31'd0, 3'd2);
        4: configure(31'($urandom), 31'($urandom), 31'($urandom >> $urandom_range(31)),
                     3'($urandom));
        default: configure(31'd0, 31'd0, 31'h0000_2000, 3'd0);
      endcase
      for (int w = 0; w < WHEELS; w++)
        send_request(load_req(2'(w), 31'($urandom >> $urandom_range(31, 1)),
                              31'($urandom >> $urandom_range(31, 1)) | 31'd1));
      quiet = (ph == 0);
      long_stall_go = (ph == 2);
      target = sent + 310;
      while (sent < target) begin
        if ($urandom_range(99) < 10) noise_request();
        else random_call($urandom_range(4, 1));
      end
      quiet = 0;
    end

    in_valid_i = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
